// File: src/psp_pkg.sv
// Shared constants, types and tables for the path step to polar converter.
package psp_pkg;

  // Coordinate handling: the input fields are 12 bits, of which COORD_WIDTH are used.
  localparam int COORD_WIDTH = 12;
  localparam int IN_W        = 12;
  localparam int CW          = (COORD_WIDTH < IN_W) ? COORD_WIDTH : IN_W;
  localparam int DIFF_W      = CW + 1;

  // Output field widths.
  localparam int DX_W   = 13;
  localparam int LEN_W  = 13;
  localparam int ANG_W  = 9;

  // Square root datapath: the sum of squares and the digit-by-digit root.
  localparam int SQ_W    = 2 * CW + 1;
  localparam int ROOT_W  = CW + 1;
  localparam int SQ_SH_W = $clog2(SQ_W);

  // CORDIC datapath.
  localparam int VEC_SHIFT    = 20;
  localparam int CORDIC_ITERS = 20;
  localparam int ANGLE_FRAC   = 16;
  localparam int CV_W         = DIFF_W + VEC_SHIFT + 3;
  localparam int Z_W          = ANGLE_FRAC + 11;
  localparam int Q_W          = Z_W - ANGLE_FRAC + 1;
  localparam int IDX_W        = $clog2(CORDIC_ITERS);
  localparam int ANG_MAX      = 180;

  // atan(2^-i) in degrees, scaled by 2^16 and rounded to nearest.
  localparam int ATAN_DEG [CORDIC_ITERS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  // Half turn in accumulator units.
  localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(ANG_MAX * (2 ** ANGLE_FRAC));

  // One step between two path points.
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } psp_step_t;

  // Working word that travels down the cell chain.
  typedef struct packed {
    psp_step_t              step;
    logic signed [CV_W-1:0] cx;
    logic signed [CV_W-1:0] cy;
    logic signed [Z_W-1:0]  cz;
    logic [SQ_W-1:0]        rem;
    logic [SQ_W-1:0]        root;
  } psp_work_t;

endpackage

// File: src/psp_in_if.sv
// Input channel: one path point per word.
interface psp_in_if;
  import psp_pkg::*;

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] x_coord;
  logic [IN_W-1:0] y_coord;
  logic            starts_path;

  modport source (output valid, output x_coord, output y_coord, output starts_path,
                  input ready);
  modport sink (input valid, input x_coord, input y_coord, input starts_path,
                output ready);
endinterface

// File: src/psp_out_if.sv
// Result channel: one step in polar form per word.
interface psp_out_if;
  import psp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DX_W-1:0]  step_dx;
  logic signed [DX_W-1:0]  step_dy;
  logic [LEN_W-1:0]        step_length;
  logic signed [ANG_W-1:0] step_angle;

  modport source (output valid, output step_dx, output step_dy, output step_length,
                  output step_angle, input ready);
  modport sink (input valid, input step_dx, input step_dy, input step_length,
                input step_angle, output ready);
endinterface

// File: src/point_step_to_polar_top.sv
// Path: a result word passes through the front, prep, 20 CORDIC and square root cells
// and the output register.
// Throughput: one point per cycle unless stalled; set by the cells, one rotation each.
// Backpressure stalls only the stages that are full; bubbles are squeezed out.
// Reset clears the stored point, the previous-point flag and all stage valids.
module point_step_to_polar_top (
  input  logic       clk,
  input  logic       rst_n,
  psp_in_if.sink     in_ch,
  psp_out_if.source  out_ch
);
  import psp_pkg::*;

  logic      step_v;
  psp_step_t step_d;
  logic      step_rdy;
  logic      chain_v   [CORDIC_ITERS+1];
  psp_work_t chain_d   [CORDIC_ITERS+1];
  logic      chain_rdy [CORDIC_ITERS+1];

  // Step from the stored point.
  psp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .dn_valid (step_v),
    .dn_data  (step_d),
    .dn_ready (step_rdy)
  );

  // Squares and the CORDIC start vector.
  psp_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (step_v),
    .up_data  (step_d),
    .up_ready (step_rdy),
    .dn_valid (chain_v[0]),
    .dn_data  (chain_d[0]),
    .dn_ready (chain_rdy[0])
  );

  // Chain of cells, one iteration each.
  for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_cell
    psp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (IDX_W'(k)),
      .up_valid (chain_v[k]),
      .up_data  (chain_d[k]),
      .up_ready (chain_rdy[k]),
      .dn_valid (chain_v[k+1]),
      .dn_data  (chain_d[k+1]),
      .dn_ready (chain_rdy[k+1])
    );
  end

  // Rounding and the result register.
  psp_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (chain_v[CORDIC_ITERS]),
    .up_data  (chain_d[CORDIC_ITERS]),
    .up_ready (chain_rdy[CORDIC_ITERS]),
    .out_ch   (out_ch)
  );
endmodule

// File: src/psp_front.sv
// Front stage: keeps the previous point and forms the step to the new one.
module psp_front (
  input  logic               clk,
  input  logic               rst_n,
  psp_in_if.sink             in_ch,
  output logic               dn_valid,
  output psp_pkg::psp_step_t dn_data,
  input  logic               dn_ready
);
  import psp_pkg::*;

  logic [CW-1:0]            prev_x_r;
  logic [CW-1:0]            prev_y_r;
  logic                     have_prev_r;
  logic                     v_r;
  psp_step_t                step_r;
  logic [CW-1:0]            xc;
  logic [CW-1:0]            yc;
  logic signed [DIFF_W-1:0] dx_c;
  logic signed [DIFF_W-1:0] dy_c;
  logic                     emit;
  logic                     accept;

  // Step from the stored point; a path start or the first point only primes, a zero step is dropped.
  assign xc     = in_ch.x_coord[CW-1:0];
  assign yc     = in_ch.y_coord[CW-1:0];
  assign dx_c   = $signed({1'b0, xc}) - $signed({1'b0, prev_x_r});
  assign dy_c   = $signed({1'b0, yc}) - $signed({1'b0, prev_y_r});
  assign emit   = !in_ch.starts_path && have_prev_r && ((dx_c != '0) || (dy_c != '0));

  assign in_ch.ready = !v_r || dn_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // Stored point and the stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      v_r         <= 1'b0;
    end else begin
      if (accept) begin
        prev_x_r    <= xc;
        prev_y_r    <= yc;
        have_prev_r <= 1'b1;
      end
      if (in_ch.ready) begin
        v_r <= accept && emit;
      end
    end
  end

  // Step payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      step_r.dx <= dx_c;
      step_r.dy <= dy_c;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = step_r;
endmodule

// File: src/psp_prep.sv
// Preparation stage: sum of squares and the CORDIC start vector.
module psp_prep (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  psp_pkg::psp_step_t up_data,
  output logic               up_ready,
  output logic               dn_valid,
  output psp_pkg::psp_work_t dn_data,
  input  logic               dn_ready
);
  import psp_pkg::*;

  logic                       v_r;
  psp_work_t                  work_r;
  psp_work_t                  work_nxt;
  logic signed [2*DIFF_W-1:0] pxx;
  logic signed [2*DIFF_W-1:0] pyy;
  logic signed [CV_W-1:0]     vx;
  logic signed [CV_W-1:0]     vy;

  assign up_ready = !v_r || dn_ready;

  // Squares of the step and the scaled vector, turned by a half turn when dy is negative.
  always_comb begin
    pxx = up_data.dx * up_data.dx;
    pyy = up_data.dy * up_data.dy;
    vx  = CV_W'(up_data.dy) <<< VEC_SHIFT;
    vy  = CV_W'(up_data.dx) <<< VEC_SHIFT;
    work_nxt.step = up_data;
    work_nxt.rem  = SQ_W'(pxx) + SQ_W'(pyy);
    work_nxt.root = '0;
    if (up_data.dy[DIFF_W-1]) begin
      work_nxt.cx = -vx;
      work_nxt.cy = -vy;
      work_nxt.cz = up_data.dx[DIFF_W-1] ? -Z_HALF_TURN : Z_HALF_TURN;
    end else begin
      work_nxt.cx = vx;
      work_nxt.cy = vy;
      work_nxt.cz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      work_r <= work_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = work_r;
endmodule

// File: src/psp_cell.sv
// One cell of the chain: a CORDIC vectoring rotation and one square root digit.
module psp_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [psp_pkg::IDX_W-1:0] idx,
  input  logic                     up_valid,
  input  psp_pkg::psp_work_t       up_data,
  output logic                     up_ready,
  output logic                     dn_valid,
  output psp_pkg::psp_work_t       dn_data,
  input  logic                     dn_ready
);
  import psp_pkg::*;

  logic                   v_r;
  psp_work_t              work_r;
  psp_work_t              work_nxt;
  logic signed [CV_W-1:0] xs;
  logic signed [CV_W-1:0] ys;
  logic signed [Z_W-1:0]  at;
  logic [SQ_SH_W-1:0]     sh;
  logic [SQ_W-1:0]        sbit;
  logic [SQ_W:0]          trial;

  assign up_ready = !v_r || dn_ready;

  always_comb begin
    work_nxt = up_data;

    // Rotate toward the x axis; the sign of y picks the direction.
    xs = up_data.cx >>> idx;
    ys = up_data.cy >>> idx;
    at = Z_W'(ATAN_DEG[idx]);
    if (!up_data.cy[CV_W-1]) begin
      work_nxt.cx = up_data.cx + ys;
      work_nxt.cy = up_data.cy - xs;
      work_nxt.cz = up_data.cz + at;
    end else begin
      work_nxt.cx = up_data.cx - ys;
      work_nxt.cy = up_data.cy + xs;
      work_nxt.cz = up_data.cz - at;
    end

    // Square root digit, from the top one down; cells past the last digit pass it on.
    sh    = SQ_SH_W'(2 * (ROOT_W - 1)) - SQ_SH_W'({idx, 1'b0});
    sbit  = SQ_W'(1) << sh;
    trial = {1'b0, up_data.root} + {1'b0, sbit};
    if (idx < IDX_W'(ROOT_W)) begin
      if ({1'b0, up_data.rem} >= trial) begin
        work_nxt.rem  = up_data.rem - SQ_W'(trial);
        work_nxt.root = (up_data.root >> 1) + sbit;
      end else begin
        work_nxt.root = up_data.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      work_r <= work_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = work_r;
endmodule

// File: src/psp_finish.sv
// Final stage: rounds length and angle and holds the result word.
module psp_finish (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  psp_pkg::psp_work_t up_data,
  output logic               up_ready,
  psp_out_if.source          out_ch
);
  import psp_pkg::*;

  logic                    v_r;
  logic signed [DX_W-1:0]  dx_r;
  logic signed [DX_W-1:0]  dy_r;
  logic [LEN_W-1:0]        len_r;
  logic signed [ANG_W-1:0] ang_r;
  logic [Z_W-1:0]          zmag;
  logic [Z_W:0]            zsum;
  logic [Q_W-1:0]          mag;
  logic signed [Q_W-1:0]   q;
  logic signed [Q_W-1:0]   qc;
  logic [ROOT_W:0]         len;

  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(ANG_MAX);

  assign up_ready = !v_r || out_ch.ready;

  // Angle: round half away from zero to whole degrees, then clamp.
  always_comb begin
    zmag = up_data.cz[Z_W-1] ? unsigned'(-up_data.cz) : unsigned'(up_data.cz);
    zsum = {1'b0, zmag} + (Z_W + 1)'(2 ** (ANGLE_FRAC - 1));
    mag  = zsum[Z_W:ANGLE_FRAC];
    q    = up_data.cz[Z_W-1] ? -signed'(mag) : signed'(mag);
    if (q > Q_MAX) begin
      qc = Q_MAX;
    end else if (q < -Q_MAX) begin
      qc = -Q_MAX;
    end else begin
      qc = q;
    end
  end

  // Length: the floor root goes up by one when the remainder exceeds it.
  assign len = {1'b0, up_data.root[ROOT_W-1:0]} + (ROOT_W + 1)'(up_data.rem > up_data.root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dx_r  <= DX_W'(up_data.step.dx);
      dy_r  <= DX_W'(up_data.step.dy);
      len_r <= LEN_W'(len);
      ang_r <= ANG_W'(qc);
    end
  end

  assign out_ch.valid       = v_r;
  assign out_ch.step_dx     = dx_r;
  assign out_ch.step_dy     = dy_r;
  assign out_ch.step_length = len_r;
  assign out_ch.step_angle  = ang_r;
endmodule

// File: verif/tb.sv
// Self-checking testbench for the path step to polar converter: directed and random paths.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psp_pkg::*;

  // Fixed-point layout of the angle calculation.
  localparam int  SCALE_SH   = 20;
  localparam int  FRAC_SH    = 16;
  localparam int  TURN_STEPS = 20;
  localparam int  COORD_MAX  = 4095;
  localparam int  IDLE_LIMIT = 2000;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  MAX_PRINTS = 40;
  localparam int  RANDOM_ITEMS = 1280;

  // atan(2^-i) in degrees with 16 fractional bits.
  localparam longint TURN_STEP_DEG [TURN_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct {
    logic signed [DX_W-1:0]  dx;
    logic signed [DX_W-1:0]  dy;
    logic [LEN_W-1:0]        length;
    logic signed [ANG_W-1:0] angle;
  } polar_word_t;

  logic clk = 1'b0;
  logic rst_n;

  psp_in_if  in_ch ();
  psp_out_if out_ch ();

  point_step_to_polar_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Copy of the block's stored point.
  int          last_x;
  int          last_y;
  bit          has_last;
  polar_word_t pending_polar[$];
  int          mismatch_count;

  // Sender and receiver idling controls.
  int burst_left;
  bit tx_steady;
  bit rx_steady;
  bit rx_open;
  int rx_left;
  int idle_cycles;

  // Rounded integer square root, half up.
  function automatic longint unsigned rounded_root(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    for (int k = 15; k >= 0; k--) begin
      b = r | (64'd1 << k);
      if (b * b <= s) r = b;
    end
    if (s > r * r + r) r++;
    return r;
  endfunction

  // Heading of (dx, dy) in whole degrees, zero along positive y, by vectoring rotations.
  function automatic int heading_deg(int dx, int dy);
    longint cx;
    longint cy;
    longint cz;
    longint xs;
    longint ys;
    longint q;
    cx = longint'(dy) <<< SCALE_SH;
    cy = longint'(dx) <<< SCALE_SH;
    cz = 0;
    // Lower half plane: rotate by a half turn first.
    if (dy < 0) begin
      cx = -cx;
      cy = -cy;
      cz = longint'(dx >= 0 ? 180 : -180) <<< FRAC_SH;
    end
    for (int i = 0; i < TURN_STEPS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy >= 0) begin
        cx = cx + ys;
        cy = cy - xs;
        cz = cz + TURN_STEP_DEG[i];
      end else begin
        cx = cx - ys;
        cy = cy + xs;
        cz = cz - TURN_STEP_DEG[i];
      end
    end
    // Round half away from zero, then clamp to a half turn.
    if (cz >= 0) q = (cz + (64'sd1 <<< (FRAC_SH - 1))) >>> FRAC_SH;
    else q = -((-cz + (64'sd1 <<< (FRAC_SH - 1))) >>> FRAC_SH);
    if (q > 180) q = 180;
    if (q < -180) q = -180;
    return int'(q);
  endfunction

  // Update the stored point and queue the polar word that the step causes.
  function automatic void advance_path(int x, int y, bit starts);
    int          dx;
    int          dy;
    bit          priming;
    polar_word_t w;
    x = x & ((1 << CW) - 1);
    y = y & ((1 << CW) - 1);
    priming = starts || !has_last;
    dx = x - last_x;
    dy = y - last_y;
    last_x = x;
    last_y = y;
    has_last = 1'b1;
    if (priming || (dx == 0 && dy == 0)) return;
    w.dx     = DX_W'(dx);
    w.dy     = DX_W'(dy);
    w.length = LEN_W'(rounded_root(longint'(dx * dx + dy * dy)));
    w.angle  = ANG_W'(heading_deg(dx, dy));
    pending_polar.push_back(w);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < MAX_PRINTS)
      $display("tb: mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Compare one accepted result word with the oldest expectation.
  task automatic check_polar_word();
    polar_word_t w;
    if (pending_polar.size() == 0) begin
      report_mismatch("unexpected word, dx", int'(out_ch.step_dx), 0);
      return;
    end
    w = pending_polar.pop_front();
    if (out_ch.step_dx !== w.dx) report_mismatch("step_dx", int'(out_ch.step_dx), int'(w.dx));
    if (out_ch.step_dy !== w.dy) report_mismatch("step_dy", int'(out_ch.step_dy), int'(w.dy));
    if (out_ch.step_length !== w.length)
      report_mismatch("step_length", int'(out_ch.step_length), int'(w.length));
    if (out_ch.step_angle !== w.angle)
      report_mismatch("step_angle", int'(out_ch.step_angle), int'(w.angle));
  endtask

  // Send one point; the sender idles between bursts unless held steady.
  task automatic send_point(int x, int y, bit starts);
    if (!tx_steady && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = $urandom_range(16, 1);
    end
    in_ch.valid       <= 1'b1;
    in_ch.x_coord     <= IN_W'(x);
    in_ch.y_coord     <= IN_W'(y);
    in_ch.starts_path <= starts;
    do @(posedge clk); while (!in_ch.ready);
    advance_path(x, y, starts);
    if (burst_left > 0) burst_left--;
  endtask

  // Receiver: checks accepted words and stalls on its own on/off pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_open = 1'b0;
      rx_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_polar_word();
      if (rx_steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_open = !rx_open;
          rx_left = rx_open ? $urandom_range(12, 1) : $urandom_range(8, 1);
        end
        rx_left--;
        out_ch.ready <= rx_open;
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no word moving on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // The first point after reset only primes the stored point.
  task automatic test_first_point();
    send_point(100, 200, 1'b0);
    send_point(100, 201, 1'b0);
  endtask

  // Steps along both axes and the four diagonals, including straight down.
  task automatic test_axis_steps();
    send_point(101, 201, 1'b0);
    send_point(100, 201, 1'b0);
    send_point(100, 200, 1'b0);
    send_point(100, 201, 1'b0);
    send_point(101, 202, 1'b0);
    send_point(100, 201, 1'b0);
    send_point(101, 200, 1'b0);
    send_point(100, 201, 1'b0);
  endtask

  // Full-range coordinates and the steps near a half turn.
  task automatic test_extremes();
    send_point(0, 0, 1'b1);
    send_point(COORD_MAX, COORD_MAX, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(COORD_MAX, 0, 1'b0);
    send_point(0, COORD_MAX, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(1, COORD_MAX, 1'b0);
    send_point(0, 0, 1'b0);
  endtask

  // Zero steps give no word; a path start primes without a word.
  task automatic test_zero_and_restart();
    send_point(0, 0, 1'b0);
    send_point(5, 5, 1'b1);
    send_point(5, 5, 1'b0);
    send_point(9, 8, 1'b0);
  endtask

  // Random paths: mostly short walks, with zero steps, jumps and stray path starts.
  task automatic test_random_paths(int n_items);
    int sent;
    int px;
    int py;
    int path_len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      tx_steady = ($urandom_range(4, 0) == 0);
      rx_steady = tx_steady;
      px = $urandom_range(COORD_MAX, 0);
      py = $urandom_range(COORD_MAX, 0);
      send_point(px, py, 1'b1);
      sent++;
      path_len = $urandom_range(40, 1);
      for (int k = 0; k < path_len; k++) begin
        pick = $urandom_range(99, 0);
        if (pick < 65) begin
          px = clamp_coord(px + int'($urandom_range(6, 0)) - 3);
          py = clamp_coord(py + int'($urandom_range(6, 0)) - 3);
        end else if (pick < 93 && pick >= 78) begin
          px = $urandom_range(COORD_MAX, 0);
          py = $urandom_range(COORD_MAX, 0);
        end else if (pick >= 93 && pick < 97) begin
          px = clamp_coord(px + int'($urandom_range(128, 0)) - 64);
          py = clamp_coord(py + int'($urandom_range(128, 0)) - 64);
        end else if (pick >= 97) begin
          px = $urandom_range(COORD_MAX, 0);
          py = $urandom_range(COORD_MAX, 0);
        end
        send_point(px, py, pick >= 97);
        sent++;
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.x_coord     <= '0;
    in_ch.y_coord     <= '0;
    in_ch.starts_path <= 1'b0;
    last_x = 0;
    last_y = 0;
    has_last = 1'b0;
    burst_left = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_point();
    test_axis_steps();
    test_extremes();
    test_zero_and_restart();
    test_random_paths(RANDOM_ITEMS);

    // Drain the pipeline, then watch for stray words.
    in_ch.valid <= 1'b0;
    while (pending_polar.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// File: sim.f
src/psp_pkg.sv
src/psp_in_if.sv
src/psp_out_if.sv
src/psp_front.sv
src/psp_prep.sv
src/psp_cell.sv
src/psp_finish.sv
src/point_step_to_polar_top.sv
verif/tb.sv
